### hdl/calidx_pkg.sv
// Shared types and constants for the content-addressed log index.
package calidx_pkg;

    localparam int SEC_W        = 48;
    localparam int HASH_W       = 256;
    localparam int WORD_W       = 64;
    localparam int OP_W         = 3;
    localparam int STAT_W       = 3;
    localparam int CFG_IDX_W    = 1;
    localparam int SECTOR_BYTES = 512;
    localparam int SECTOR_SHIFT = $clog2(SECTOR_BYTES);

    localparam logic [WORD_W-1:0] LOG_MAGIC  = 64'h424F_4C42_4245_5245;
    localparam logic [SEC_W-1:0]  BASE_RESET = 48'd34816;
    localparam logic [SEC_W-1:0]  SEC_MAX    = {SEC_W{1'b1}};

    // operation codes
    localparam logic [OP_W-1:0] OP_FIND    = 3'd0;
    localparam logic [OP_W-1:0] OP_STORE   = 3'd1;
    localparam logic [OP_W-1:0] OP_RECOVER = 3'd2;
    localparam logic [OP_W-1:0] OP_MARK    = 3'd3;
    localparam logic [OP_W-1:0] OP_COMPACT = 3'd4;

    // status codes
    localparam logic [STAT_W-1:0] ST_OK         = 3'd0;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND  = 3'd1;
    localparam logic [STAT_W-1:0] ST_TABLE_FULL = 3'd2;
    localparam logic [STAT_W-1:0] ST_LOG_FULL   = 3'd3;
    localparam logic [STAT_W-1:0] ST_BAD_HEADER = 3'd4;
    localparam logic [STAT_W-1:0] ST_ZERO_SIZE  = 3'd5;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BASE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_END  = 1'd1;

    // controller to datapath
    typedef struct packed {
        logic in_ready;
        logic scan;
        logic finish;
        logic clear;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic needs_scan;
        logic scan_stop;
        logic out_busy;
        logic done_now;
        logic clr_last;
    } sts_t;

    // data sectors behind a header: ceil(bytes / SECTOR_BYTES)
    function automatic logic [SEC_W-1:0] data_sectors(input logic [SEC_W-1:0] bytes);
        logic [SEC_W:0] sum;
        begin
            sum = {1'b0, bytes} + (SEC_W+1)'(SECTOR_BYTES - 1);
            data_sectors = SEC_W'(sum >> SECTOR_SHIFT);
        end
    endfunction

endpackage

### hdl/calidx_if.sv
// Request, response and configuration channel interfaces.
interface calidx_req_if;
    import calidx_pkg::*;
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   op;
    logic [WORD_W-1:0] hash_word_0;
    logic [WORD_W-1:0] hash_word_1;
    logic [WORD_W-1:0] hash_word_2;
    logic [WORD_W-1:0] hash_word_3;
    logic [SEC_W-1:0]  object_bytes;
    logic [WORD_W-1:0] header_magic;
    logic [SEC_W-1:0]  header_seq;
    modport source (output valid, op, hash_word_0, hash_word_1, hash_word_2, hash_word_3,
                    object_bytes, header_magic, header_seq, input ready);
    modport sink (input valid, op, hash_word_0, hash_word_1, hash_word_2, hash_word_3,
                  object_bytes, header_magic, header_seq, output ready);
endinterface

interface calidx_rsp_if #(parameter int CNT_W = 13);
    import calidx_pkg::*;
    logic              valid;
    logic              ready;
    logic [STAT_W-1:0] status;
    logic [SEC_W-1:0]  entry_sector;
    logic [SEC_W-1:0]  entry_bytes;
    logic [SEC_W-1:0]  seq_for_header;
    logic              reused;
    logic              move_needed;
    logic [SEC_W-1:0]  move_source;
    logic [SEC_W-1:0]  move_data_sectors;
    logic              compact_done;
    logic [CNT_W-1:0]  entry_count;
    logic [SEC_W-1:0]  free_sectors;
    modport source (output valid, status, entry_sector, entry_bytes, seq_for_header, reused,
                    move_needed, move_source, move_data_sectors, compact_done, entry_count,
                    free_sectors, input ready);
    modport sink (input valid, status, entry_sector, entry_bytes, seq_for_header, reused,
                  move_needed, move_source, move_data_sectors, compact_done, entry_count,
                  free_sectors, output ready);
endinterface

interface calidx_cfg_if;
    import calidx_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [SEC_W-1:0]     data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

### hdl/content_addressed_log_index_top.sv
// Top level of the content-addressed log index: controller plus datapath.
//
//  channel | dir | handshake    | payload
//  req     | in  | valid/ready  | op, hash words, object_bytes, header_magic, header_seq
//  rsp     | out | valid/ready  | status, sectors, sizes, move order, counts
//  cfg     | in  | valid/ready  | index (0 base, 1 end), data
//
// Find, store and mark live scan the table one entry a cycle.
// A compact step scans live marks from its cursor; recover and other codes skip the scan.
// The compaction done step and reset run a live-mark clear pass over all MAX_ENTRIES entries,
// during which no request is taken; configuration writes are always taken.
// The result register lets a new request enter while the previous result waits.
module content_addressed_log_index_top #(
    parameter int MAX_ENTRIES = 4096,
    parameter int CNT_W       = 13
) (
    input logic          clk,
    input logic          rst_n,
    calidx_req_if.sink   req,
    calidx_rsp_if.source rsp,
    calidx_cfg_if.sink   cfg
);
    import calidx_pkg::*;

    cmd_t cmd;
    sts_t sts;

    calidx_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .sts       (sts),
        .cmd       (cmd)
    );

    calidx_dp #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .CNT_W       (CNT_W)
    ) u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .cfg   (cfg),
        .cmd   (cmd),
        .sts   (sts)
    );

endmodule

### hdl/calidx_ctrl.sv
// Sequencer for the log index: clear pass, idle, table scan and finish.
module calidx_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    input  calidx_pkg::sts_t  sts,
    output calidx_pkg::cmd_t  cmd
);
    import calidx_pkg::*;

    localparam logic [1:0] S_CLEAR  = 2'd0;
    localparam logic [1:0] S_IDLE   = 2'd1;
    localparam logic [1:0] S_SCAN   = 2'd2;
    localparam logic [1:0] S_FINISH = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    // commands and next state
    always_comb
    begin
        state_next   = state_reg;
        cmd.in_ready = 1'b0;
        cmd.scan     = 1'b0;
        cmd.finish   = 1'b0;
        cmd.clear    = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (sts.clr_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                cmd.in_ready = 1'b1;
                if (req_valid)
                    state_next = sts.needs_scan ? S_SCAN : S_FINISH;
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (sts.scan_stop)
                    state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (!sts.out_busy)
                begin
                    cmd.finish = 1'b1;
                    state_next = sts.done_now ? S_CLEAR : S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_CLEAR;
        else
            state_reg <= state_next;
    end

endmodule

### hdl/calidx_dp.sv
// Datapath: entry memories, allocator registers, scan pipeline, result register.
module calidx_dp #(
    parameter int MAX_ENTRIES = 4096,
    parameter int CNT_W       = 13
) (
    input  logic             clk,
    input  logic             rst_n,
    calidx_req_if.sink       req,
    calidx_rsp_if.source     rsp,
    calidx_cfg_if.sink       cfg,
    input  calidx_pkg::cmd_t cmd,
    output calidx_pkg::sts_t sts
);
    import calidx_pkg::*;

    localparam int IDX_W = $clog2(MAX_ENTRIES);

    // entry memories
    logic [HASH_W-1:0] name_mem  [MAX_ENTRIES];
    logic [SEC_W-1:0]  start_mem [MAX_ENTRIES];
    logic [SEC_W-1:0]  len_mem   [MAX_ENTRIES];
    logic              live_mem  [MAX_ENTRIES];

    logic [HASH_W-1:0] name_q;
    logic [SEC_W-1:0]  start_q;
    logic [SEC_W-1:0]  len_q;
    logic              live_q;

    // configuration and allocator state
    logic [SEC_W-1:0]  base_reg, end_reg, nfs_reg, dest_reg, nseq_reg;
    logic [CNT_W-1:0]  used_reg, cursor_reg, kept_reg;
    logic [SEC_W-1:0]  nfs_next, dest_next, nseq_next;
    logic [CNT_W-1:0]  used_next, cursor_next, kept_next;

    // latched request
    logic [OP_W-1:0]   op_reg;
    logic [HASH_W-1:0] hash_reg;
    logic [SEC_W-1:0]  bytes_reg, seq_reg;
    logic [WORD_W-1:0] magic_reg;

    // scan pipeline and first hit
    logic [CNT_W-1:0]  issue_reg, idx1_reg, clr_reg;
    logic              v1_reg;
    logic              hit_reg;
    logic [CNT_W-1:0]  hit_idx_reg;
    logic [SEC_W-1:0]  hit_start_reg, hit_len_reg;
    logic [HASH_W-1:0] hit_name_reg;

    // result register
    logic              out_valid_reg;
    logic [STAT_W-1:0] out_status_reg;
    logic [SEC_W-1:0]  out_sector_reg, out_bytes_reg, out_seq_reg;
    logic              out_reused_reg, out_move_reg, out_done_reg;
    logic [SEC_W-1:0]  out_src_reg, out_secs_reg, out_free_reg;
    logic [CNT_W-1:0]  out_count_reg;

    // finish results
    logic [STAT_W-1:0] r_status;
    logic [SEC_W-1:0]  r_sector, r_bytes, r_seq, r_src, r_secs, r_free;
    logic              r_reused, r_move, r_done;

    logic              accept, can_issue, rd_en, hit_now, mark_we;
    logic              app_en, mv_en, st_we;
    logic [SEC_W-1:0]  ds, hit_secs;
    logic [SEC_W:0]    need_end;
    logic              table_full;

    logic              name_we, len_we, live_we;
    logic [IDX_W-1:0]  wr_a, live_a, rd_a;
    logic [HASH_W-1:0] name_wd;
    logic [SEC_W-1:0]  len_wd, start_wd;
    logic              live_wd;

    assign accept    = cmd.in_ready && req.valid;
    assign req.ready = cmd.in_ready;
    assign cfg.ready = 1'b1;

    // scan control
    assign can_issue = issue_reg < used_reg;
    assign rd_en     = cmd.scan && can_issue;
    assign rd_a      = issue_reg[IDX_W-1:0];
    assign hit_now   = v1_reg && ((op_reg == OP_COMPACT) ? live_q : (name_q == hash_reg));
    assign mark_we   = cmd.scan && hit_now && (op_reg == OP_MARK);

    assign sts.needs_scan = (req.op != OP_RECOVER) && (req.op <= OP_COMPACT);
    assign sts.scan_stop  = (hit_now && (op_reg != OP_MARK)) || (!v1_reg && !can_issue);
    assign sts.out_busy   = out_valid_reg && !rsp.ready;
    assign sts.done_now   = (op_reg == OP_COMPACT) && !hit_reg;
    assign sts.clr_last   = clr_reg == CNT_W'(MAX_ENTRIES - 1);

    assign ds         = data_sectors(bytes_reg);
    assign hit_secs   = data_sectors(hit_len_reg);
    assign need_end   = {1'b0, nfs_reg} + (SEC_W+1)'(1) + {1'b0, ds};
    assign table_full = used_reg >= CNT_W'(MAX_ENTRIES);

    // result and state update for the finishing item
    always_comb
    begin
        r_status    = ST_OK;
        r_sector    = '0;
        r_bytes     = '0;
        r_seq       = '0;
        r_reused    = 1'b0;
        r_move      = 1'b0;
        r_src       = '0;
        r_secs      = '0;
        r_done      = 1'b0;
        app_en      = 1'b0;
        mv_en       = 1'b0;
        st_we       = 1'b0;
        nseq_next   = nseq_reg;
        dest_next   = dest_reg;
        cursor_next = cursor_reg;
        kept_next   = kept_reg;
        case (op_reg)
            OP_FIND, OP_MARK:
            begin
                if (hit_reg)
                begin
                    r_sector = hit_start_reg;
                    r_bytes  = hit_len_reg;
                end
                else
                    r_status = ST_NOT_FOUND;
            end
            OP_STORE:
            begin
                if (bytes_reg == '0)
                    r_status = ST_ZERO_SIZE;
                else if (hit_reg && (hit_len_reg == bytes_reg))
                begin
                    r_sector = hit_start_reg;
                    r_bytes  = bytes_reg;
                    r_reused = 1'b1;
                end
                else if (table_full)
                    r_status = ST_TABLE_FULL;
                else if (need_end > {1'b0, end_reg})
                    r_status = ST_LOG_FULL;
                else
                begin
                    r_sector = nfs_reg;
                    r_bytes  = bytes_reg;
                    r_seq    = nseq_reg;
                    if (nseq_reg != SEC_MAX)
                        nseq_next = nseq_reg + SEC_W'(1);
                    app_en = 1'b1;
                end
            end
            OP_RECOVER:
            begin
                if ((nfs_reg < base_reg) || (nfs_reg >= end_reg) ||
                    (magic_reg != LOG_MAGIC) || (bytes_reg == '0) ||
                    (need_end > {1'b0, end_reg}))
                    r_status = ST_BAD_HEADER;
                else if (table_full)
                    r_status = ST_TABLE_FULL;
                else
                begin
                    if (seq_reg >= nseq_reg)
                        nseq_next = (seq_reg != SEC_MAX) ? seq_reg + SEC_W'(1) : SEC_MAX;
                    r_sector = nfs_reg;
                    r_bytes  = bytes_reg;
                    r_seq    = nseq_next;
                    app_en   = 1'b1;
                end
            end
            OP_COMPACT:
            begin
                r_sector = dest_reg;
                if (hit_reg)
                begin
                    r_bytes     = hit_len_reg;
                    r_move      = hit_start_reg != dest_reg;
                    r_src       = hit_start_reg;
                    r_secs      = hit_secs;
                    mv_en       = kept_reg != hit_idx_reg;
                    st_we       = 1'b1;
                    kept_next   = kept_reg + CNT_W'(1);
                    cursor_next = hit_idx_reg + CNT_W'(1);
                    dest_next   = dest_reg + SEC_W'(1) + hit_secs;
                end
                else
                begin
                    r_done      = 1'b1;
                    kept_next   = '0;
                    cursor_next = '0;
                    dest_next   = base_reg;
                end
            end
            default:
            begin
                r_status = ST_OK;
            end
        endcase
        used_next = used_reg;
        nfs_next  = nfs_reg;
        if (app_en)
        begin
            used_next = used_reg + CNT_W'(1);
            nfs_next  = nfs_reg + SEC_W'(1) + ds;
        end
        else if (r_done)
        begin
            used_next = kept_reg;
            nfs_next  = dest_reg;
        end
        r_free = (end_reg > nfs_next) ? end_reg - nfs_next : '0;
    end

    // memory write selection
    always_comb
    begin
        name_we  = cmd.finish && (app_en || mv_en);
        len_we   = name_we;
        wr_a     = app_en ? used_reg[IDX_W-1:0] : kept_reg[IDX_W-1:0];
        name_wd  = app_en ? hash_reg : hit_name_reg;
        len_wd   = app_en ? bytes_reg : hit_len_reg;
        start_wd = app_en ? nfs_reg : dest_reg;
        live_we  = 1'b0;
        live_a   = wr_a;
        live_wd  = 1'b0;
        if (cmd.clear)
        begin
            live_we = 1'b1;
            live_a  = clr_reg[IDX_W-1:0];
        end
        else if (mark_we)
        begin
            live_we = 1'b1;
            live_a  = idx1_reg[IDX_W-1:0];
            live_wd = 1'b1;
        end
        else if (name_we)
        begin
            live_we = 1'b1;
            live_wd = mv_en;
        end
    end

    // memories
    always_ff @(posedge clk)
    begin
        if (name_we)
            name_mem[wr_a] <= name_wd;
        if (len_we)
            len_mem[wr_a] <= len_wd;
        if (cmd.finish && (app_en || st_we))
            start_mem[wr_a] <= start_wd;
        if (live_we)
            live_mem[live_a] <= live_wd;
        if (rd_en)
        begin
            name_q  <= name_mem[rd_a];
            start_q <= start_mem[rd_a];
            len_q   <= len_mem[rd_a];
            live_q  <= live_mem[rd_a];
        end
    end

    // request capture and first-hit capture
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg    <= req.op;
            hash_reg  <= {req.hash_word_3, req.hash_word_2, req.hash_word_1, req.hash_word_0};
            bytes_reg <= req.object_bytes;
            magic_reg <= req.header_magic;
            seq_reg   <= req.header_seq;
        end
        if (cmd.scan && hit_now && !hit_reg)
        begin
            hit_idx_reg   <= idx1_reg;
            hit_start_reg <= start_q;
            hit_len_reg   <= len_q;
            hit_name_reg  <= name_q;
        end
        if (cmd.finish)
        begin
            out_status_reg <= r_status;
            out_sector_reg <= r_sector;
            out_bytes_reg  <= r_bytes;
            out_seq_reg    <= r_seq;
            out_reused_reg <= r_reused;
            out_move_reg   <= r_move;
            out_src_reg    <= r_src;
            out_secs_reg   <= r_secs;
            out_done_reg   <= r_done;
            out_count_reg  <= used_next;
            out_free_reg   <= r_free;
        end
    end

    // control and allocator registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg      <= BASE_RESET;
            end_reg       <= '0;
            nfs_reg       <= BASE_RESET;
            dest_reg      <= BASE_RESET;
            nseq_reg      <= '0;
            used_reg      <= '0;
            cursor_reg    <= '0;
            kept_reg      <= '0;
            issue_reg     <= '0;
            idx1_reg      <= '0;
            v1_reg        <= 1'b0;
            hit_reg       <= 1'b0;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                issue_reg <= (req.op == OP_COMPACT) ? cursor_reg : '0;
                v1_reg    <= 1'b0;
                hit_reg   <= 1'b0;
            end
            else if (cmd.scan)
            begin
                v1_reg   <= can_issue;
                idx1_reg <= issue_reg;
                if (can_issue)
                    issue_reg <= issue_reg + CNT_W'(1);
                if (hit_now)
                    hit_reg <= 1'b1;
            end
            if (cmd.clear)
                clr_reg <= clr_reg + CNT_W'(1);
            else
                clr_reg <= '0;
            if (cmd.finish)
            begin
                used_reg   <= used_next;
                nfs_reg    <= nfs_next;
                dest_reg   <= dest_next;
                nseq_reg   <= nseq_next;
                cursor_reg <= cursor_next;
                kept_reg   <= kept_next;
            end
            if (cmd.finish)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
            // the user must write registers only while idle; the block does not enforce this
            if (cfg.valid)
            begin
                if (cfg.index == CFG_BASE)
                begin
                    base_reg <= cfg.data;
                    if (used_reg == '0)
                    begin
                        nfs_reg  <= cfg.data;
                        dest_reg <= cfg.data;
                    end
                end
                else if (cfg.index == CFG_END)
                    end_reg <= cfg.data;
            end
        end
    end

    assign rsp.valid             = out_valid_reg;
    assign rsp.status            = out_status_reg;
    assign rsp.entry_sector      = out_sector_reg;
    assign rsp.entry_bytes       = out_bytes_reg;
    assign rsp.seq_for_header    = out_seq_reg;
    assign rsp.reused            = out_reused_reg;
    assign rsp.move_needed       = out_move_reg;
    assign rsp.move_source       = out_src_reg;
    assign rsp.move_data_sectors = out_secs_reg;
    assign rsp.compact_done      = out_done_reg;
    assign rsp.entry_count       = out_count_reg;
    assign rsp.free_sectors      = out_free_reg;

`ifndef SYNTHESIS
    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= CNT_W'(MAX_ENTRIES))
        else $error("entry count above table size");
    a_kept_cursor: assert property (@(posedge clk) disable iff (!rst_n)
        kept_reg <= cursor_reg)
        else $error("compaction destination slot passed the cursor");
    a_finish_out: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> out_valid_reg)
        else $error("finished request left no result");
    a_scan_idx: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.scan && v1_reg) |-> (idx1_reg < used_reg))
        else $error("scan compared an entry beyond the table fill");
`endif

endmodule

### verif/calidx_checker.sv
// Checker for the log index: watches the channels, predicts each response and compares.
`timescale 1ns / 1ps
module calidx_checker
    import calidx_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    calidx_req_if  req,
    calidx_rsp_if  rsp,
    calidx_cfg_if  cfg,
    output int     errors,
    output int     pending
);
    localparam int DEPTH = 4096;
    localparam longint unsigned M48 = 64'hFFFF_FFFF_FFFF;

    // sector-sized fields are kept at 64 bits; every stored value stays within 48
    typedef struct {
        logic [STAT_W-1:0] status;
        longint unsigned   sector;
        longint unsigned   nbytes;
        longint unsigned   seq;
        logic              reused;
        logic              move;
        longint unsigned   src;
        longint unsigned   dsec;
        logic              done;
        int                count;
        longint unsigned   free;
    } index_result_t;

    // mirror of the index state
    bit [63:0]       tag0 [DEPTH];
    bit [63:0]       tag1 [DEPTH];
    bit [63:0]       tag2 [DEPTH];
    bit [63:0]       tag3 [DEPTH];
    longint unsigned start_sec [DEPTH];
    longint unsigned len_bytes [DEPTH];
    bit              live [DEPTH];
    int              used, cursor, kept;
    longint unsigned base_sec, end_sec, next_free, next_seq, dest_sec;

    index_result_t results_due[$];

    assign pending = results_due.size();

    function automatic longint unsigned sector_span(longint unsigned b);
        return (b + SECTOR_BYTES - 1) / SECTOR_BYTES;
    endfunction

    function automatic bit same_tag(int i, bit [63:0] w0, bit [63:0] w1, bit [63:0] w2,
                                    bit [63:0] w3);
        return tag0[i] == w0 && tag1[i] == w1 && tag2[i] == w2 && tag3[i] == w3;
    endfunction

    function automatic int lookup(bit [63:0] w0, bit [63:0] w1, bit [63:0] w2, bit [63:0] w3);
        for (int i = 0; i < used && i < DEPTH; i++)
            if (same_tag(i, w0, w1, w2, w3)) return i;
        return -1;
    endfunction

    function automatic void push_entry(bit [63:0] w0, bit [63:0] w1, bit [63:0] w2,
                                       bit [63:0] w3, longint unsigned b);
        tag0[used] = w0; tag1[used] = w1; tag2[used] = w2; tag3[used] = w3;
        start_sec[used] = next_free;
        len_bytes[used] = b;
        live[used] = 0;
        used++;
        next_free = (next_free + 1 + sector_span(b)) & M48;
    endfunction

    // one request in, one expected response out; updates the mirror
    function automatic index_result_t predict_index(logic [OP_W-1:0] op, bit [63:0] w0,
            bit [63:0] w1, bit [63:0] w2, bit [63:0] w3, longint unsigned b,
            bit [63:0] magic, longint unsigned hseq);
        index_result_t r;
        int i, c;
        longint unsigned at, secs;
        r = '{default: '0};
        case (op)
            OP_FIND: begin
                i = lookup(w0, w1, w2, w3);
                if (i < 0) r.status = ST_NOT_FOUND;
                else begin
                    r.sector = start_sec[i];
                    r.nbytes = len_bytes[i];
                end
            end
            OP_STORE: begin
                i = lookup(w0, w1, w2, w3);
                if (b == 0) r.status = ST_ZERO_SIZE;
                else if (i >= 0 && len_bytes[i] == b) begin
                    r.sector = start_sec[i];
                    r.nbytes = b;
                    r.reused = 1;
                end
                else if (used >= DEPTH) r.status = ST_TABLE_FULL;
                else if (next_free + 1 + sector_span(b) > end_sec) r.status = ST_LOG_FULL;
                else begin
                    r.sector = next_free;
                    r.nbytes = b;
                    r.seq = next_seq;
                    if (next_seq < M48) next_seq++;
                    push_entry(w0, w1, w2, w3, b);
                end
            end
            OP_RECOVER: begin
                at = next_free;
                if (at < base_sec || at >= end_sec || magic != LOG_MAGIC || b == 0 ||
                    at + 1 + sector_span(b) > end_sec)
                    r.status = ST_BAD_HEADER;
                else if (used >= DEPTH) r.status = ST_TABLE_FULL;
                else begin
                    if (hseq >= next_seq) next_seq = (hseq < M48) ? hseq + 1 : M48;
                    r.sector = at;
                    r.nbytes = b;
                    r.seq = next_seq;
                    push_entry(w0, w1, w2, w3, b);
                end
            end
            OP_MARK: begin
                i = lookup(w0, w1, w2, w3);
                if (i < 0) r.status = ST_NOT_FOUND;
                else begin
                    r.sector = start_sec[i];
                    r.nbytes = len_bytes[i];
                    for (int j = i; j < used && j < DEPTH; j++)
                        if (same_tag(j, w0, w1, w2, w3)) live[j] = 1;
                end
            end
            OP_COMPACT: begin
                c = cursor;
                while (c < used && c < DEPTH && !live[c]) c++;
                if (c < used && c < DEPTH) begin
                    secs = sector_span(len_bytes[c]);
                    r.sector = dest_sec;
                    r.nbytes = len_bytes[c];
                    r.move = start_sec[c] != dest_sec;
                    r.src = start_sec[c];
                    r.dsec = secs;
                    if (kept != c) begin
                        tag0[kept] = tag0[c]; tag1[kept] = tag1[c];
                        tag2[kept] = tag2[c]; tag3[kept] = tag3[c];
                        len_bytes[kept] = len_bytes[c];
                        live[kept] = live[c];
                    end
                    start_sec[kept] = dest_sec;
                    kept++;
                    cursor = c + 1;
                    dest_sec = (dest_sec + 1 + secs) & M48;
                end
                else begin
                    r.sector = dest_sec;
                    r.done = 1;
                    used = kept;
                    next_free = dest_sec;
                    foreach (live[k]) live[k] = 0;
                    cursor = 0;
                    kept = 0;
                    dest_sec = base_sec;
                end
            end
            default: ;  // unused codes leave everything alone
        endcase
        r.count = used;
        r.free = (end_sec > next_free) ? end_sec - next_free : 0;
        return r;
    endfunction

    task automatic report(string field, longint unsigned got, longint unsigned want);
        $display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, field, got, want);
        errors++;
    endtask

    function automatic void apply_config(logic [CFG_IDX_W-1:0] idx, logic [SEC_W-1:0] val);
        if (idx == CFG_BASE) begin
            base_sec = val;
            if (used == 0) begin
                next_free = val;
                dest_sec = val;
            end
        end
        else if (idx == CFG_END) end_sec = val;
    endfunction

    // response check first, then new request, then configuration
    always @(posedge clk or negedge rst_n) begin
        index_result_t want;
        if (!rst_n) begin
            errors = 0;
            results_due.delete();
            foreach (live[k]) live[k] = 0;
            used = 0; cursor = 0; kept = 0;
            base_sec = BASE_RESET; end_sec = 0;
            next_free = BASE_RESET; next_seq = 0; dest_sec = BASE_RESET;
        end
        else begin
            if (rsp.valid && rsp.ready) begin
                if (results_due.size() == 0) begin
                    $display("%0t: response with nothing outstanding", $realtime);
                    errors++;
                end
                else begin
                    want = results_due.pop_front();
                    if (rsp.status !== want.status) report("status", rsp.status, want.status);
                    if (rsp.entry_sector !== want.sector)
                        report("entry_sector", rsp.entry_sector, want.sector);
                    if (rsp.entry_bytes !== want.nbytes)
                        report("entry_bytes", rsp.entry_bytes, want.nbytes);
                    if (rsp.seq_for_header !== want.seq)
                        report("seq_for_header", rsp.seq_for_header, want.seq);
                    if (rsp.reused !== want.reused) report("reused", rsp.reused, want.reused);
                    if (rsp.move_needed !== want.move)
                        report("move_needed", rsp.move_needed, want.move);
                    if (rsp.move_source !== want.src)
                        report("move_source", rsp.move_source, want.src);
                    if (rsp.move_data_sectors !== want.dsec)
                        report("move_data_sectors", rsp.move_data_sectors, want.dsec);
                    if (rsp.compact_done !== want.done)
                        report("compact_done", rsp.compact_done, want.done);
                    if (rsp.entry_count !== want.count)
                        report("entry_count", rsp.entry_count, want.count);
                    if (rsp.free_sectors !== want.free)
                        report("free_sectors", rsp.free_sectors, want.free);
                end
            end
            if (req.valid && req.ready)
                results_due.push_back(predict_index(req.op, req.hash_word_0, req.hash_word_1,
                    req.hash_word_2, req.hash_word_3, req.object_bytes, req.header_magic,
                    req.header_seq));
            if (cfg.valid && cfg.ready) apply_config(cfg.index, cfg.data);
        end
    end

endmodule

### verif/tb_top.sv
// Testbench top for the log index: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module tb_top;
    import calidx_pkg::*;

    localparam int LIMIT = 4_000_000;
    localparam int NTAGS = 8;
    localparam int CLEAR_WAIT = 4200;
    localparam logic [SEC_W-1:0] S_MAX = {SEC_W{1'b1}};

    logic clk;
    logic rst_n;
    int   errors, pending, cycles, sent, settings;
    bit   idle_on;
    bit [63:0]       tags [NTAGS][4];
    logic [SEC_W-1:0] tag_size [NTAGS];

    calidx_req_if req ();
    calidx_rsp_if rsp ();
    calidx_cfg_if cfg ();

    content_addressed_log_index_top uut (.clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp),
                                         .cfg(cfg));

    calidx_checker chk (.clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp), .cfg(cfg),
                        .errors(errors), .pending(pending));

    always begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // response side back-pressure
    always @(posedge clk)
        rsp.ready <= idle_on ? ($urandom_range(99) >= 33) : 1'b1;

    // run limit
    always @(posedge clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // one request, held until taken; leaves valid high
    task automatic send(logic [OP_W-1:0] op, int t, logic [SEC_W-1:0] nbytes,
                        logic [WORD_W-1:0] magic, logic [SEC_W-1:0] hseq);
        if (idle_on && $urandom_range(99) < 33) begin
            req.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        req.valid        <= 1'b1;
        req.op           <= op;
        req.hash_word_0  <= tags[t][0];
        req.hash_word_1  <= tags[t][1];
        req.hash_word_2  <= tags[t][2];
        req.hash_word_3  <= tags[t][3];
        req.object_bytes <= nbytes;
        req.header_magic <= magic;
        req.header_seq   <= hseq;
        @(posedge clk);
        while (!req.ready) @(posedge clk);
        sent++;
    endtask

    // stop sending and wait for every outstanding response
    task automatic drain();
        req.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [SEC_W-1:0] val);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= val;
        @(posedge clk);
        while (!cfg.ready) @(posedge clk);
        cfg.valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [SEC_W-1:0] pick_size(int t);
        case ($urandom_range(9))
            0: return SEC_W'(1);
            1: return SEC_W'(SECTOR_BYTES);
            2: return SEC_W'(SECTOR_BYTES + 1);
            3, 4, 5: return tag_size[t];
            6: return SEC_W'($urandom_range(1, 3000));
            7: return SEC_W'({$urandom, $urandom});
            8: return '0;
            default: return SEC_W'($urandom_range(1, 200));
        endcase
    endfunction

    // mostly well-formed traffic over a small set of names
    task automatic random_item();
        int t, k;
        logic [OP_W-1:0] op;
        logic [WORD_W-1:0] magic;
        logic [SEC_W-1:0] hseq;
        t = $urandom_range(NTAGS - 1);
        k = $urandom_range(99);
        if (k < 22) op = OP_FIND;
        else if (k < 50) op = OP_STORE;
        else if (k < 62) op = OP_RECOVER;
        else if (k < 78) op = OP_MARK;
        else if (k < 95) op = OP_COMPACT;
        else op = OP_W'($urandom_range(5, 7));
        magic = ($urandom_range(9) == 0) ? {$urandom, $urandom} : LOG_MAGIC;
        hseq = ($urandom_range(3) == 0) ? SEC_W'({$urandom, $urandom}) :
                                          SEC_W'($urandom_range(0, 300));
        send(op, t, pick_size(t), magic, hseq);
    endtask

    initial begin
        req.valid = 1'b0; req.op = OP_FIND;
        req.hash_word_0 = '0; req.hash_word_1 = '0; req.hash_word_2 = '0; req.hash_word_3 = '0;
        req.object_bytes = '0; req.header_magic = '0; req.header_seq = '0;
        cfg.valid = 1'b0; cfg.index = CFG_BASE; cfg.data = '0;
        idle_on = 1'b1;
        cycles = 0; sent = 0; settings = 1;
        for (int t = 0; t < NTAGS; t++) begin
            for (int w = 0; w < 4; w++) tags[t][w] = {$urandom, $urandom};
            tag_size[t] = SEC_W'($urandom_range(1, 1500));
        end
        tags[0] = '{default: '0};
        tags[1] = '{default: '1};
        tags[3][3] = ~tags[2][3];  // same leading words as tag 2, last word differs
        tags[3][0:2] = tags[2][0:2];

        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        while (!req.ready) @(posedge clk);  // clear pass after reset

        // reset settings: log end at zero, nothing fits
        send(OP_FIND, 0, 0, 0, 0);
        send(OP_STORE, 0, 100, 0, 0);
        send(OP_STORE, 1, 0, 0, 0);
        send(OP_RECOVER, 2, 100, LOG_MAGIC, 0);
        send(3'd5, 1, S_MAX, '1, S_MAX);
        send(3'd7, 0, 0, 0, 0);
        send(OP_COMPACT, 0, 0, 0, 0);
        drain();

        // base write with an empty table moves the allocator
        write_reg(CFG_BASE, 48'd1000);
        write_reg(CFG_END, 48'd400000);
        settings++;
        send(OP_STORE, 0, 512, 0, 0);
        send(OP_STORE, 0, 512, 0, 0);          // reuse
        send(OP_STORE, 0, 513, 0, 0);          // size differs: new copy
        send(OP_FIND, 0, 0, 0, 0);
        send(OP_RECOVER, 2, 1, LOG_MAGIC, S_MAX);  // sequence saturates
        send(OP_STORE, 3, 1000, 0, 0);
        send(OP_RECOVER, 1, 10, ~LOG_MAGIC, 5);
        send(OP_RECOVER, 1, 0, LOG_MAGIC, 5);
        send(OP_RECOVER, 1, S_MAX, LOG_MAGIC, 5);  // does not fit
        send(OP_STORE, 1, S_MAX, 0, 0);        // log full
        send(OP_MARK, 0, 0, 0, 0);
        send(OP_MARK, 4, 0, 0, 0);
        send(OP_COMPACT, 0, 0, 0, 0);
        send(OP_FIND, 0, 0, 0, 0);             // stale copy still visible
        send(OP_COMPACT, 0, 0, 0, 0);
        send(OP_COMPACT, 0, 0, 0, 0);
        send(OP_COMPACT, 0, 0, 0, 0);
        drain();

        // random traffic with idling
        for (int n = 0; n < 40; n++) begin
            if (n == 20) drain();              // sender holds off until all is back
            random_item();
        end
        drain();

        // widest log, base at zero; long stretch without idling
        write_reg(CFG_END, S_MAX);
        write_reg(CFG_BASE, '0);
        settings++;
        idle_on = 1'b0;
        for (int n = 0; n < 20; n++) random_item();

        // a run of recovered headers, then fresh names and a compaction sweep
        for (int n = 0; n < 10; n++) send(OP_RECOVER, n % NTAGS, 1, LOG_MAGIC, SEC_W'(n));
        tags[5][0] = ~tags[5][0];
        send(OP_STORE, 5, 64, 0, 0);
        send(OP_RECOVER, 5, 64, LOG_MAGIC, 0);
        send(OP_MARK, 6, 0, 0, 0);
        for (int n = 0; n < 10; n++) send(OP_COMPACT, 0, 0, 0, 0);
        drain();

        // base near the top of the sector range
        idle_on = 1'b1;
        write_reg(CFG_BASE, S_MAX - 48'd4000);
        write_reg(CFG_END, 48'd123457);
        settings++;
        for (int n = 0; n < 30; n++) random_item();
        drain();
        repeat (CLEAR_WAIT) @(posedge clk);

        $display("Sent %0d requests over %0d register settings, with table growth,",
                 sent, settings);
        $display("compaction, recovery and back-pressure on both channels.");
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

### sim.f
hdl/calidx_pkg.sv
hdl/calidx_if.sv
hdl/calidx_ctrl.sv
hdl/calidx_dp.sv
hdl/content_addressed_log_index_top.sv
verif/calidx_checker.sv
verif/tb_top.sv
